// File: src/scp_pkg.sv
// Shared types and codes for the sector cache tag and policy controller.
// No dependencies; used by scp_tag_store and sector_cache_tag_policy.
package scp_pkg;

  // Width of the slot field on the result port.
  localparam int SLOT_W = 6;

  // Request action codes.
  localparam logic [1:0] ACT_READ       = 2'd0;
  localparam logic [1:0] ACT_WRITE      = 2'd1;
  localparam logic [1:0] ACT_FLUSH      = 2'd2;
  localparam logic [1:0] ACT_FLUSH_INVAL = 2'd3;

  // Sequencer states.
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_LOOK,
    ST_FLUSH,
    ST_OUT
  } state_t;

  // Write commands from the sequencer to the tag store.
  typedef struct packed {
    logic tag_we;
    logic line_we;
    logic line_valid;
    logic line_dirty;
    logic clear_all;
  } store_cmd_t;

  // Valid and dirty bits of the slot read in the previous cycle.
  typedef struct packed {
    logic valid;
    logic dirty;
  } line_stat_t;

endpackage

// File: src/scp_tag_store.sv
// Tag memory with registered read, plus per-slot valid and dirty flops.
// Depends on scp_pkg for the command and status structs.
module scp_tag_store #(
  parameter int SLOTS = 64,
  parameter int IDX_W = (SLOTS > 1) ? $clog2(SLOTS) : 1
) (
  input  logic                clk,
  input  logic                rst,
  input  logic [IDX_W-1:0]    rd_addr,
  output logic [31:0]         rd_tag,
  output scp_pkg::line_stat_t rd_stat,
  input  logic [IDX_W-1:0]    wr_addr,
  input  logic [31:0]         wr_tag,
  input  scp_pkg::store_cmd_t cmd
);

  logic [31:0]      tag_mem [SLOTS];
  logic [SLOTS-1:0] valid;
  logic [SLOTS-1:0] dirty;

  // Tag memory: one write port and one registered read port.
  always_ff @(posedge clk) begin
    if (cmd.tag_we) begin
      tag_mem[wr_addr] <= wr_tag;
    end
    rd_tag <= tag_mem[rd_addr];
  end

  // Valid and dirty bits; a clear of all slots wins over a single update.
  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= '0;
      dirty <= '0;
    end else if (cmd.clear_all) begin
      valid <= '0;
      dirty <= '0;
    end else if (cmd.line_we) begin
      valid[wr_addr] <= cmd.line_valid;
      dirty[wr_addr] <= cmd.line_dirty;
    end
  end

  // Status read alongside the tag, at the same address.
  always_ff @(posedge clk) begin
    rd_stat.valid <= valid[rd_addr];
    rd_stat.dirty <= dirty[rd_addr];
  end

endmodule

// File: src/sector_cache_tag_policy.sv
// Read or write: the tag scan stops at the matching slot on a hit and walks every slot
// on a miss; the result word then stays in the result register until taken. Flush:
// each dirty slot costs a scan to it plus an output word, and the walk then resumes
// just past it. The rate is set by the one tag memory read port, walked one slot a
// cycle through a single comparator while no result word is waiting to be taken.
// Reset (synchronous, active high) clears valid and dirty bits at once; tags stay undefined.
module sector_cache_tag_policy #(
  parameter int SLOTS = 64
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        in_valid,
  output logic                        in_ready,
  input  logic [1:0]                  action,
  input  logic [31:0]                 sector,
  output logic                        out_valid,
  input  logic                        out_ready,
  output logic [scp_pkg::SLOT_W-1:0]  slot,
  output logic                        hit,
  output logic                        fill_needed,
  output logic                        writeback_needed,
  output logic [31:0]                 writeback_sector,
  output logic                        last
);

  localparam int IDX_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam int CNT_W = $clog2(SLOTS + 1);
  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(SLOTS - 1);

  scp_pkg::state_t     state, state_next;
  logic [CNT_W-1:0]    cnt, cnt_next;
  logic                pend, pend_next;
  logic [IDX_W-1:0]    pend_idx, pend_idx_next;
  logic [1:0]          act_q, act_q_next;
  logic [31:0]         sector_q, sector_q_next;
  logic                free_found, free_found_next;
  logic [IDX_W-1:0]    free_idx, free_idx_next;
  logic [31:0]         vtag, vtag_next;
  logic                vdirty, vdirty_next;
  logic [IDX_W-1:0]    vp, vp_next;
  logic [CNT_W-1:0]    dcount, dcount_next;

  logic [scp_pkg::SLOT_W-1:0] slot_next;
  logic                       hit_next, fill_next, wb_next, last_next;
  logic [31:0]                wbs_next;

  logic [IDX_W-1:0]    rd_addr, wr_addr;
  logic [31:0]         rd_tag, wr_tag;
  scp_pkg::line_stat_t rd_stat;
  scp_pkg::store_cmd_t cmd;

  logic                in_acc, out_acc, is_wr;
  logic                match, scan_end, flush_hit;
  logic [IDX_W-1:0]    vnext, miss_idx;
  logic                old_dirty;
  logic [31:0]         old_tag;
  logic                free_now;

  scp_tag_store #(
    .SLOTS (SLOTS),
    .IDX_W (IDX_W)
  ) u_store (
    .clk     (clk),
    .rst     (rst),
    .rd_addr (rd_addr),
    .rd_tag  (rd_tag),
    .rd_stat (rd_stat),
    .wr_addr (wr_addr),
    .wr_tag  (wr_tag),
    .cmd     (cmd)
  );

  assign in_ready  = (state == scp_pkg::ST_IDLE);
  assign out_valid = (state == scp_pkg::ST_OUT);
  assign in_acc    = in_valid && in_ready;
  assign out_acc   = out_valid && out_ready;
  assign is_wr     = (act_q == scp_pkg::ACT_WRITE);

  // Shared compare unit: the slot read last cycle against the request.
  assign match     = pend && rd_stat.valid && (rd_tag == sector_q);
  assign scan_end  = pend && !match && (pend_idx == LAST_IDX);
  assign flush_hit = pend && rd_stat.valid && rd_stat.dirty;

  // Round-robin victim: increment first, then use.
  assign vnext = (vp == LAST_IDX) ? '0 : vp + 1'b1;

  // Miss placement: lowest free slot, else the victim.
  assign free_now  = free_found || !rd_stat.valid;
  assign miss_idx  = free_found ? free_idx : (free_now ? pend_idx : vnext);
  assign old_dirty = free_now ? 1'b0 : ((pend_idx == vnext) ? rd_stat.dirty : vdirty);
  assign old_tag   = (pend_idx == vnext) ? rd_tag : vtag;

  // Next state.
  always_comb begin
    state_next = state;
    case (state)
      scp_pkg::ST_IDLE: begin
        if (in_acc) begin
          if (action[1] && (dcount == '0)) begin
            state_next = scp_pkg::ST_OUT;
          end else if (action[1]) begin
            state_next = scp_pkg::ST_FLUSH;
          end else begin
            state_next = scp_pkg::ST_LOOK;
          end
        end
      end
      scp_pkg::ST_LOOK: begin
        if (match || scan_end) begin
          state_next = scp_pkg::ST_OUT;
        end
      end
      scp_pkg::ST_FLUSH: begin
        if (flush_hit) begin
          state_next = scp_pkg::ST_OUT;
        end
      end
      scp_pkg::ST_OUT: begin
        if (out_acc) begin
          state_next = last ? scp_pkg::ST_IDLE : scp_pkg::ST_FLUSH;
        end
      end
      default: state_next = scp_pkg::ST_IDLE;
    endcase
  end

  // Datapath, store commands and result word.
  always_comb begin
    cnt_next        = cnt;
    pend_next       = pend;
    pend_idx_next   = pend_idx;
    act_q_next      = act_q;
    sector_q_next   = sector_q;
    free_found_next = free_found;
    free_idx_next   = free_idx;
    vtag_next       = vtag;
    vdirty_next     = vdirty;
    vp_next         = vp;
    dcount_next     = dcount;
    slot_next       = slot;
    hit_next        = hit;
    fill_next       = fill_needed;
    wb_next         = writeback_needed;
    wbs_next        = writeback_sector;
    last_next       = last;
    rd_addr         = cnt[IDX_W-1:0];
    wr_addr         = pend_idx;
    wr_tag          = sector_q;
    cmd             = '0;

    case (state)
      scp_pkg::ST_IDLE: begin
        if (in_acc) begin
          act_q_next      = action;
          sector_q_next   = sector;
          cnt_next        = '0;
          pend_next       = 1'b0;
          free_found_next = 1'b0;
          if (action[1] && (dcount == '0)) begin
            // Flush with nothing dirty: a single completion word.
            slot_next     = '0;
            hit_next      = 1'b0;
            fill_next     = 1'b0;
            wb_next       = 1'b0;
            wbs_next      = '0;
            last_next     = 1'b1;
            cmd.clear_all = (action == scp_pkg::ACT_FLUSH_INVAL);
          end
        end
      end

      scp_pkg::ST_LOOK: begin
        // Issue the next tag read while comparing the previous one.
        if (cnt < CNT_W'(SLOTS)) begin
          pend_next     = 1'b1;
          pend_idx_next = cnt[IDX_W-1:0];
          cnt_next      = cnt + 1'b1;
        end else begin
          pend_next = 1'b0;
        end
        if (pend && (pend_idx == vnext)) begin
          vtag_next   = rd_tag;
          vdirty_next = rd_stat.dirty;
        end
        if (match) begin
          cmd.line_we    = 1'b1;
          cmd.line_valid = 1'b1;
          cmd.line_dirty = rd_stat.dirty || is_wr;
          wr_addr        = pend_idx;
          dcount_next    = dcount + CNT_W'(is_wr && !rd_stat.dirty);
          slot_next      = scp_pkg::SLOT_W'(pend_idx);
          hit_next       = 1'b1;
          fill_next      = 1'b0;
          wb_next        = 1'b0;
          wbs_next       = '0;
          last_next      = 1'b1;
        end else if (scan_end) begin
          cmd.tag_we     = 1'b1;
          cmd.line_we    = 1'b1;
          cmd.line_valid = 1'b1;
          cmd.line_dirty = is_wr;
          wr_addr        = miss_idx;
          dcount_next    = dcount + CNT_W'(is_wr) - CNT_W'(old_dirty);
          if (!free_now) begin
            vp_next = vnext;
          end
          slot_next = scp_pkg::SLOT_W'(miss_idx);
          hit_next  = 1'b0;
          fill_next = 1'b1;
          wb_next   = old_dirty;
          wbs_next  = old_dirty ? old_tag : '0;
          last_next = 1'b1;
        end else if (pend && !rd_stat.valid && !free_found) begin
          free_found_next = 1'b1;
          free_idx_next   = pend_idx;
        end
      end

      scp_pkg::ST_FLUSH: begin
        if (cnt < CNT_W'(SLOTS)) begin
          pend_next     = 1'b1;
          pend_idx_next = cnt[IDX_W-1:0];
          cnt_next      = cnt + 1'b1;
        end else begin
          pend_next = 1'b0;
        end
        if (flush_hit) begin
          // Clean this slot and resume the walk just past it.
          cmd.line_we    = 1'b1;
          cmd.line_valid = 1'b1;
          cmd.line_dirty = 1'b0;
          wr_addr        = pend_idx;
          cnt_next       = CNT_W'(pend_idx) + 1'b1;
          pend_next      = 1'b0;
          dcount_next    = dcount - 1'b1;
          slot_next      = scp_pkg::SLOT_W'(pend_idx);
          hit_next       = 1'b0;
          fill_next      = 1'b0;
          wb_next        = 1'b1;
          wbs_next       = rd_tag;
          last_next      = (dcount == CNT_W'(1));
          cmd.clear_all  = (dcount == CNT_W'(1)) && (act_q == scp_pkg::ACT_FLUSH_INVAL);
        end
      end

      scp_pkg::ST_OUT: begin
        // Result word held until taken.
      end

      default: begin
      end
    endcase
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= scp_pkg::ST_IDLE;
      cnt        <= '0;
      pend       <= 1'b0;
      free_found <= 1'b0;
      vp         <= '0;
      dcount     <= '0;
    end else begin
      state      <= state_next;
      cnt        <= cnt_next;
      pend       <= pend_next;
      free_found <= free_found_next;
      vp         <= vp_next;
      dcount     <= dcount_next;
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    pend_idx         <= pend_idx_next;
    act_q            <= act_q_next;
    sector_q         <= sector_q_next;
    free_idx         <= free_idx_next;
    vtag             <= vtag_next;
    vdirty           <= vdirty_next;
    slot             <= slot_next;
    hit              <= hit_next;
    fill_needed      <= fill_next;
    writeback_needed <= wb_next;
    writeback_sector <= wbs_next;
    last             <= last_next;
  end

  // The dirty count never exceeds the number of slots.
  a_dcount_range: assert property (@(posedge clk) disable iff (rst)
    dcount <= CNT_W'(SLOTS))
    else $error("dirty count out of range");

  // A hit never asks for a fill or a write-back.
  a_hit_clean: assert property (@(posedge clk) disable iff (rst)
    (out_valid && hit) |-> (!fill_needed && !writeback_needed))
    else $error("hit word with fill or write-back");

  // The block never takes a request while a result is pending.
  a_one_item: assert property (@(posedge clk) disable iff (rst)
    !(in_ready && out_valid))
    else $error("request accepted while a result is pending");

  // A flush with nothing dirty gives its completion word next cycle.
  a_empty_flush: assert property (@(posedge clk) disable iff (rst)
    (in_acc && action[1] && (dcount == '0)) |=>
      (out_valid && last && !writeback_needed))
    else $error("empty flush did not complete at once");

  // Read and write requests always end in a single last word.
  a_req_last: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !act_q[1]) |-> last)
    else $error("request result without last");

endmodule

// File: sim/tb_sector_cache_tag_policy.sv
`timescale 1ns / 1ps
// Self-checking testbench for sector_cache_tag_policy: a queue-fed driver, a monitor
// and a tag/policy predictor that tracks slot tags, valid and dirty bits and the victim.
// Depends on scp_pkg and the sector_cache_tag_policy RTL.
module tb_sector_cache_tag_policy;

  localparam int SLOTS = 64;
  localparam int SLOT_W = scp_pkg::SLOT_W;
  localparam int POOL_SIZE = 96;
  localparam int RANDOM_REQUESTS = 266;
  localparam int HOLD_OFF_CYCLES = 400;
  localparam int HOLD_OFF_AFTER = 40;
  localparam int DRAIN_CYCLES = 200;
  localparam int IDLE_LIMIT = 4000;

  typedef struct {
    logic [1:0]  action;
    logic [31:0] sector;
  } request_t;

  typedef struct {
    logic [SLOT_W-1:0] slot;
    logic              hit;
    logic              fill_needed;
    logic              writeback_needed;
    logic [31:0]       writeback_sector;
    logic              last;
  } cache_word_t;

  logic                clk = 1'b1;
  logic                rst = 1'b1;
  logic                in_valid = 1'b0;
  logic                in_ready;
  logic [1:0]          action = scp_pkg::ACT_READ;
  logic [31:0]         sector = 32'd0;
  logic                out_valid;
  logic                out_ready = 1'b0;
  logic [SLOT_W-1:0]   slot;
  logic                hit;
  logic                fill_needed;
  logic                writeback_needed;
  logic [31:0]         writeback_sector;
  logic                last;

  // Predictor state.
  logic [31:0]         line_tag [SLOTS];
  logic                line_valid [SLOTS];
  logic                line_dirty [SLOTS];
  logic [SLOT_W-1:0]   victim_ptr;

  request_t            pending_requests [$];
  cache_word_t         expected_words [$];
  request_t            next_req;
  cache_word_t         want;
  logic [31:0]         sector_pool [POOL_SIZE];

  int errors = 0;
  int total_requests = 0;
  int items_accepted = 0;
  int words_checked = 0;
  int reads_seen = 0, writes_seen = 0, flushes_seen = 0, invals_seen = 0;
  int hits_seen = 0, misses_seen = 0, evictions_seen = 0, evict_writebacks = 0;
  int flush_writebacks = 0;
  logic in_took = 1'b0;
  int burst_left = 0;
  int gap_left = 0;
  int hold_left = 0;
  bit hold_done = 1'b0;
  int phase_left = 0;
  int ready_pct = 100;
  int idle_cycles = 0;

  sector_cache_tag_policy #(.SLOTS(SLOTS)) dut (
    .clk              (clk),
    .rst              (rst),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .action           (action),
    .sector           (sector),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .slot             (slot),
    .hit              (hit),
    .fill_needed      (fill_needed),
    .writeback_needed (writeback_needed),
    .writeback_sector (writeback_sector),
    .last             (last)
  );

  // Clock: 12 ns period.
  always begin
    clk = 1'b1;
    #6;
    clk = 1'b0;
    #6;
  end

  // Apply one request to the predicted cache state and queue the words it causes.
  task automatic predict_cache_access(input logic [1:0] act, input logic [31:0] sec);
    cache_word_t w;
    int idx;
    int last_dirty;
    begin
      w.slot = '0;
      w.hit = 1'b0;
      w.fill_needed = 1'b0;
      w.writeback_needed = 1'b0;
      w.writeback_sector = 32'd0;
      w.last = 1'b1;
      if (act == scp_pkg::ACT_FLUSH || act == scp_pkg::ACT_FLUSH_INVAL) begin
        if (act == scp_pkg::ACT_FLUSH) flushes_seen++;
        else invals_seen++;
        last_dirty = -1;
        for (int i = 0; i < SLOTS; i++)
          if (line_valid[i] && line_dirty[i]) last_dirty = i;
        // One write-back word per dirty slot, lowest slot first.
        for (int i = 0; i < SLOTS; i++) begin
          if (line_valid[i] && line_dirty[i]) begin
            w.slot = SLOT_W'(i);
            w.writeback_needed = 1'b1;
            w.writeback_sector = line_tag[i];
            w.last = (i == last_dirty);
            expected_words.push_back(w);
            line_dirty[i] = 1'b0;
            flush_writebacks++;
          end
          if (act == scp_pkg::ACT_FLUSH_INVAL) begin
            line_valid[i] = 1'b0;
            line_dirty[i] = 1'b0;
          end
        end
        // A flush that finds nothing dirty still answers with a completion word.
        if (last_dirty < 0) expected_words.push_back(w);
      end else begin
        if (act == scp_pkg::ACT_WRITE) writes_seen++;
        else reads_seen++;
        idx = -1;
        for (int i = 0; i < SLOTS; i++)
          if (idx < 0 && line_valid[i] && line_tag[i] == sec) idx = i;
        if (idx >= 0) begin
          w.hit = 1'b1;
          hits_seen++;
        end else begin
          misses_seen++;
          w.fill_needed = 1'b1;
          for (int i = 0; i < SLOTS; i++)
            if (idx < 0 && !line_valid[i]) idx = i;
          // Cache full: step the victim pointer first, then evict that slot.
          if (idx < 0) begin
            victim_ptr = (victim_ptr == SLOT_W'(SLOTS - 1)) ? '0 : victim_ptr + 1'b1;
            idx = int'(victim_ptr);
            evictions_seen++;
            if (line_dirty[idx]) begin
              w.writeback_needed = 1'b1;
              w.writeback_sector = line_tag[idx];
              evict_writebacks++;
            end
          end
          line_valid[idx] = 1'b1;
          line_tag[idx] = sec;
          line_dirty[idx] = 1'b0;
        end
        if (act == scp_pkg::ACT_WRITE) line_dirty[idx] = 1'b1;
        w.slot = SLOT_W'(idx);
        expected_words.push_back(w);
      end
    end
  endtask

  task automatic check_field(input string name, input logic [31:0] want_v,
                             input logic [31:0] got_v);
    if (want_v !== got_v) begin
      $display("%0t: %s mismatch, expected 0x%0h, actual 0x%0h", $time, name, want_v, got_v);
      errors++;
    end
  endtask

  task automatic add_request(input logic [1:0] act, input logic [31:0] sec);
    request_t r;
    begin
      r.action = act;
      r.sector = sec;
      pending_requests.push_back(r);
      total_requests++;
    end
  endtask

  // Sender: bursts of words separated by random gaps; a word is held until taken.
  always @(negedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (in_valid && !in_took) begin
      // Still waiting for the block to take the current word.
    end else if (gap_left > 0) begin
      gap_left--;
      in_valid <= 1'b0;
    end else if (pending_requests.size() > 0) begin
      next_req = pending_requests.pop_front();
      action <= next_req.action;
      sector <= next_req.sector;
      in_valid <= 1'b1;
      burst_left--;
      if (burst_left <= 0) begin
        burst_left = $urandom_range(1, 12);
        gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 16);
      end
    end else begin
      in_valid <= 1'b0;
    end
  end

  // Receiver: ready rate changes in phases, plus one long hold-off to back up the input.
  always @(negedge clk) begin
    if (rst) begin
      out_ready <= 1'b0;
    end else begin
      if (!hold_done && items_accepted >= HOLD_OFF_AFTER) begin
        hold_left = HOLD_OFF_CYCLES;
        hold_done = 1'b1;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_ready <= 1'b0;
      end else begin
        if (phase_left == 0) begin
          phase_left = $urandom_range(20, 80);
          case ($urandom_range(0, 3))
            0: ready_pct = 100;
            1: ready_pct = 75;
            2: ready_pct = 40;
            default: ready_pct = 10;
          endcase
        end
        phase_left--;
        out_ready <= ($urandom_range(1, 100) <= ready_pct);
      end
    end
  end

  // Monitor: check every result word taken, then predict from every request taken.
  always @(posedge clk) begin
    if (rst) begin
      in_took <= 1'b0;
    end else begin
      in_took <= in_valid && in_ready;
      if (out_valid && out_ready) begin
        if (expected_words.size() == 0) begin
          $display("%0t: unexpected result word, expected none, actual slot 0x%0h last %0b",
                   $time, slot, last);
          errors++;
        end else begin
          want = expected_words.pop_front();
          check_field("slot", 32'(want.slot), 32'(slot));
          check_field("hit", 32'(want.hit), 32'(hit));
          check_field("fill_needed", 32'(want.fill_needed), 32'(fill_needed));
          check_field("writeback_needed", 32'(want.writeback_needed),
                      32'(writeback_needed));
          check_field("writeback_sector", want.writeback_sector, writeback_sector);
          check_field("last", 32'(want.last), 32'(last));
          words_checked++;
        end
      end
      if (in_valid && in_ready) begin
        predict_cache_access(action, sector);
        items_accepted++;
      end
    end
  end

  // Watchdog: end the run if nothing moves on either side for too long.
  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("%0t: no word accepted for %0d cycles", $time, IDLE_LIMIT);
      $display("tb_sector_cache_tag_policy failed");
      $finish;
    end
  end

  initial begin
    int r;
    logic [1:0] act;
    logic [31:0] sec;
    for (int i = 0; i < SLOTS; i++) begin
      line_tag[i] = 32'd0;
      line_valid[i] = 1'b0;
      line_dirty[i] = 1'b0;
    end
    victim_ptr = '0;

    // Directed: field extremes, hits and misses, dirty tracking, empty and full flushes.
    add_request(scp_pkg::ACT_READ, 32'h0000_0000);
    add_request(scp_pkg::ACT_WRITE, 32'hFFFF_FFFF);
    add_request(scp_pkg::ACT_READ, 32'hFFFF_FFFF);
    add_request(scp_pkg::ACT_WRITE, 32'h0000_0000);
    add_request(scp_pkg::ACT_READ, 32'h1234_5678);
    add_request(scp_pkg::ACT_FLUSH, 32'hDEAD_BEEF);
    add_request(scp_pkg::ACT_FLUSH, 32'h0000_0000);
    add_request(scp_pkg::ACT_WRITE, 32'hA5A5_A5A5);
    add_request(scp_pkg::ACT_READ, 32'hA5A5_A5A5);
    add_request(scp_pkg::ACT_FLUSH_INVAL, 32'hFFFF_FFFF);
    add_request(scp_pkg::ACT_FLUSH_INVAL, 32'h0000_0000);
    add_request(scp_pkg::ACT_READ, 32'h1234_5678);
    add_request(scp_pkg::ACT_WRITE, 32'h5A5A_5A5A);
    add_request(scp_pkg::ACT_WRITE, 32'h8000_0000);

    // Random: mostly reads and writes over a pool a bit larger than the cache, so it
    // fills, hits often and evicts often; some fresh sectors and occasional flushes.
    for (int i = 0; i < POOL_SIZE; i++) sector_pool[i] = $urandom();
    sector_pool[0] = 32'h0000_0000;
    sector_pool[1] = 32'hFFFF_FFFF;
    for (int n = 0; n < RANDOM_REQUESTS; n++) begin
      r = $urandom_range(0, 199);
      if (r < 2) act = scp_pkg::ACT_FLUSH_INVAL;
      else if (r < 10) act = scp_pkg::ACT_FLUSH;
      else if (r < 105) act = scp_pkg::ACT_READ;
      else act = scp_pkg::ACT_WRITE;
      if ($urandom_range(0, 9) == 0) sec = $urandom();
      else sec = sector_pool[$urandom_range(0, POOL_SIZE - 1)];
      add_request(act, sec);
    end

    repeat (10) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    while (items_accepted < total_requests) @(posedge clk);
    while (expected_words.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("Covered %0d requests: %0d reads, %0d writes, %0d flushes, %0d invalidating.",
             items_accepted, reads_seen, writes_seen, flushes_seen, invals_seen);
    $display("%0d hits, %0d misses, %0d evictions (%0d dirty), %0d flush write-backs, %0d words.",
             hits_seen, misses_seen, evictions_seen, evict_writebacks, flush_writebacks,
             words_checked);
    if (errors == 0) begin
      $display("tb_sector_cache_tag_policy passed");
    end else begin
      $display("tb_sector_cache_tag_policy failed");
    end
    $finish;
  end

endmodule
